/* hdl/slstk_pkg.sv */
// slstk_pkg: shared constants, codes, types and helpers for the searchable LIFO stack.
// No dependencies; imported by every module of the block.
package slstk_pkg;

    localparam int DEPTH   = 128;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 7;
    localparam int OCC_W   = 8;

    // operation codes (s_tuser)
    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LARGEST = 2'd3;

    // result status codes (m_tuser)
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_NOTFOUND = 2'd3;

    // cell shift modes
    typedef logic [1:0] cell_mode_t;
    localparam cell_mode_t MODE_HOLD = 2'd0;
    localparam cell_mode_t MODE_DOWN = 2'd1;  // take word from the cell nearer the top
    localparam cell_mode_t MODE_UP   = 2'd2;  // take word from the cell farther from the top

    // per-cycle control of the scan unit
    typedef struct packed {
        logic             clear;        // any accepted transfer; starts a new scan
        logic             step;         // cell 0 holds an entry to examine
        logic             first;        // first entry of the scan (the top)
        logic             range_ok;     // entry lies below the fill count
        logic             is_search;    // search, else largest
        logic [IDX_W-1:0] entry_index;  // stack index of the word in cell 0
    } scan_ctl_t;

    function automatic logic [FOUND_W-1:0] to_found(input logic [IDX_W-1:0] idx);
        logic [FOUND_W+IDX_W-1:0] wide;
        wide = {{FOUND_W{1'b0}}, idx};
        return wide[FOUND_W-1:0];
    endfunction

    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
        logic [OCC_W+CNT_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, cnt};
        return wide[OCC_W-1:0];
    endfunction

endpackage

/* hdl/slstk_cell.sv */
// slstk_cell: one storage cell of the stack shift chain.
// Depends on slstk_pkg.
module slstk_cell
    import slstk_pkg::*;
(
    input  logic              aclk,
    input  cell_mode_t        mode,
    input  logic [WORD_W-1:0] from_top,
    input  logic [WORD_W-1:0] from_bottom,
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        case (mode)
            MODE_DOWN: word_next = from_top;
            MODE_UP:   word_next = from_bottom;
            default:   word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* hdl/slstk_scan.sv */
// slstk_scan: compare unit watching cell 0 while the chain rotates.
// Tracks the topmost match for search and the running maximum. Depends on slstk_pkg.
module slstk_scan
    import slstk_pkg::*;
(
    input  logic              aclk,
    input  scan_ctl_t         ctl,
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] key,
    output logic              found,
    output logic [IDX_W-1:0]  found_idx,
    output logic [WORD_W-1:0] best
);

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] best_reg, best_next;

    always_comb begin
        found_next = found_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
            idx_next   = '0;
        end else if (ctl.step && ctl.range_ok) begin
            if (ctl.is_search) begin
                // keep the first (topmost) hit only
                if (!found_reg && word == key) begin
                    found_next = 1'b1;
                    idx_next   = ctl.entry_index;
                end
            end else if (ctl.first || $signed(word) > $signed(best_reg)) begin
                best_next = word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
    end

    assign found     = found_reg;
    assign found_idx = idx_reg;
    assign best      = best_reg;

endmodule

/* hdl/searchable_lifo_stack.sv */
// searchable_lifo_stack: top level of a LIFO of signed words with search and largest.
// Depends on slstk_pkg, slstk_cell and slstk_scan.
//
//  channel  dir  tdata (low bit up)                               tuser
//  s_       in   value[31:0]                                      kind[1:0]
//  m_       out  data_out[31:0] found_index[38:32] occ[46:39]     status[1:0]
//
// Push and pop shift the cell chain down or up by one place,
// cell 0 always holding the top of the stack.
// Search and largest rotate the chain one full turn, one cell per cycle past
// the compare unit at cell 0, which also brings the stack back to its original
// order; on an empty stack they return an empty status with no rotation.
// Reset clears the fill count and the control only; cell contents stay undefined.
// One result register parts the channels: a new transfer is taken only in the idle
// state, while it is free or being drained; a stalled m_ side holds the block after a scan.
module searchable_lifo_stack
    import slstk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // data_out[31:0], found_index[38:32], occupancy[46:39]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_K   = IDX_W'(DEPTH - 1);

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              search_reg, search_next;
    logic [WORD_W-1:0] key_reg, key_next;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [WORD_W-1:0] m_data_reg, m_data_next;
    logic [FOUND_W-1:0] m_found_reg, m_found_next;
    logic [OCC_W-1:0]  m_occ_reg, m_occ_next;

    logic              out_free;
    logic              accept;
    cell_mode_t        mode;
    scan_ctl_t         ctl;
    logic [WORD_W-1:0] cell_word [DEPTH];
    logic              sc_found;
    logic [IDX_W-1:0]  sc_idx;
    logic [WORD_W-1:0] sc_best;
    logic [CNT_W-1:0]  k_ext;
    logic [CNT_W-1:0]  entry_cnt;
    logic              empty;
    logic              full;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg >= FULL_CNT);

    // stack index of the word now in cell 0 during a scan: fill - 1 - k
    assign k_ext     = {{(CNT_W-IDX_W){1'b0}}, k_reg};
    assign entry_cnt = fill_reg - k_ext - CNT_W'(1);

    always_comb begin
        ctl.clear       = accept;
        ctl.step        = (state_reg == ST_SCAN);
        ctl.first       = (k_reg == '0);
        ctl.range_ok    = (k_ext < fill_reg);
        ctl.is_search   = search_reg;
        ctl.entry_index = entry_cnt[IDX_W-1:0];
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        k_next        = k_reg;
        search_next   = search_reg;
        key_next      = key_reg;
        mode          = MODE_HOLD;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_found_next  = m_found_reg;
        m_occ_next    = m_occ_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_status_next = STATUS_OK;
                    m_data_next   = '0;
                    m_found_next  = '0;
                    m_occ_next    = to_occ(fill_reg);
                    case (s_tuser)
                        KIND_PUSH: begin
                            m_valid_next = 1'b1;
                            if (full) begin
                                m_status_next = STATUS_OVERFLOW;
                            end else begin
                                mode       = MODE_DOWN;
                                fill_next  = fill_reg + CNT_W'(1);
                                m_occ_next = to_occ(fill_reg + CNT_W'(1));
                            end
                        end
                        KIND_POP: begin
                            m_valid_next = 1'b1;
                            if (empty) begin
                                m_status_next = STATUS_EMPTY;
                            end else begin
                                mode        = MODE_UP;
                                m_data_next = cell_word[0];
                                fill_next   = fill_reg - CNT_W'(1);
                                m_occ_next  = to_occ(fill_reg - CNT_W'(1));
                            end
                        end
                        default: begin
                            // search and largest
                            if (empty) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STATUS_EMPTY;
                            end else begin
                                search_next = (s_tuser == KIND_SEARCH);
                                key_next    = s_tdata;
                                k_next      = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                mode   = MODE_UP;  // rotate; last cell is fed from cell 0
                k_next = k_reg + IDX_W'(1);
                if (k_reg == LAST_K) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_occ_next   = to_occ(fill_reg);
                    if (search_reg) begin
                        m_status_next = sc_found ? STATUS_OK : STATUS_NOTFOUND;
                        m_data_next   = '0;
                        m_found_next  = sc_found ? to_found(sc_idx) : '0;
                    end else begin
                        m_status_next = STATUS_OK;
                        m_data_next   = sc_best;
                        m_found_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        search_reg   <= search_next;
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_found_reg  <= m_found_next;
        m_occ_reg    <= m_occ_next;
    end

    // cell chain: cell 0 is the top; push feeds it from s_tdata, and the
    // bottom cell takes cell 0 back so a full rotation restores the order
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] up_word;
        logic [WORD_W-1:0] dn_word;
        if (i == 0) begin : g_top
            assign up_word = s_tdata;
        end else begin : g_mid_up
            assign up_word = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_bot
            assign dn_word = cell_word[0];
        end else begin : g_mid_dn
            assign dn_word = cell_word[i+1];
        end
        slstk_cell u_cell (
            .aclk        (aclk),
            .mode        (mode),
            .from_top    (up_word),
            .from_bottom (dn_word),
            .word        (cell_word[i])
        );
    end

    slstk_scan u_scan (
        .aclk      (aclk),
        .ctl       (ctl),
        .word      (cell_word[0]),
        .key       (key_reg),
        .found     (sc_found),
        .found_idx (sc_idx),
        .best      (sc_best)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_occ_reg, m_found_reg, m_data_reg};

endmodule
